### design/bec_pkg.sv
package bec_pkg;

   localparam logic [7:0] CHAR_BSLASH = 8'h5C;
   localparam logic [7:0] CHAR_TAB    = 8'h09;
   localparam logic [7:0] CHAR_LF     = 8'h0A;
   localparam logic [7:0] CHAR_CR     = 8'h0D;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [7:0] CHAR_T      = 8'h74;
   localparam logic [7:0] CHAR_N      = 8'h6E;
   localparam logic [7:0] CHAR_R      = 8'h72;
   localparam logic [7:0] CHAR_S      = 8'h73;

   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;

   localparam logic [0:0] REG_DIRECTION      = 1'b0;
   localparam logic [0:0] REG_ATTRIBUTE_MODE = 1'b1;

   localparam logic DIR_ESCAPE   = 1'b0;
   localparam logic DIR_UNESCAPE = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_DANGLING = 2'd1,
      STATUS_INVALID  = 2'd2
   } status_type;

   typedef struct packed {
      logic [7:0] byte0;
      logic [7:0] byte1;
      logic [1:0] byte_count;
      logic       marker;
      status_type status;
   } job_type;

endpackage

### design/bec_req_if.sv
interface bec_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       byte_present;
   logic       end_of_field;

   modport source (output valid, output data_byte, output byte_present,
                   output end_of_field, input ready);
   modport sink (input valid, input data_byte, input byte_present,
                 input end_of_field, output ready);
endinterface

### design/bec_rsp_if.sv
interface bec_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       out_present;
   logic       field_done;
   logic [1:0] field_status;
   logic       last_of_run;

   modport source (output valid, output out_byte, output out_present,
                   output field_done, output field_status, output last_of_run,
                   input ready);
   modport sink (input valid, input out_byte, input out_present,
                 input field_done, input field_status, input last_of_run,
                 output ready);
endinterface

### design/backslash_escape_codec_unit.sv
// An accepted request is written into the job queue; its first result is then
// loaded from the queue head into the result register when that register is free.
// Throughput: one request per cycle; the result side emits one result per cycle
// while the receiver is ready, so requests expanding to two or three results drain
// through the job queue and stall the request side only when the queue fills.
// Reset: synchronous active high; clears field state, queue and registers.
module backslash_escape_codec_unit
   import bec_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = 4
)
(
   input  logic                  clock,
   input  logic                  reset,
   bec_req_if.sink               req_bus,
   bec_rsp_if.source             rsp_bus,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   logic    direction_ff;
   logic    direction_in;
   logic    attribute_mode_ff;
   logic    attribute_mode_in;
   logic    csr_write;
   logic    q_push;
   logic    q_pop;
   logic    q_full;
   logic    q_empty;
   job_type push_job;
   job_type head_job;

   assign pready = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      direction_in = direction_ff;
      attribute_mode_in = attribute_mode_ff;
      if (csr_write) begin
         unique case (paddr[2])
            REG_DIRECTION:      direction_in = pwdata[0];
            REG_ATTRIBUTE_MODE: attribute_mode_in = pwdata[0];
            default:            direction_in = direction_ff;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         REG_DIRECTION:      prdata = {{(CSR_DATA_W - 1){1'b0}}, direction_ff};
         REG_ATTRIBUTE_MODE: prdata = {{(CSR_DATA_W - 1){1'b0}}, attribute_mode_ff};
         default:            prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         direction_ff <= DIR_ESCAPE;
         attribute_mode_ff <= 1'b0;
      end else begin
         direction_ff <= direction_in;
         attribute_mode_ff <= attribute_mode_in;
      end
   end

   bec_front u_front (
      .clock          (clock),
      .reset          (reset),
      .direction      (direction_ff),
      .attribute_mode (attribute_mode_ff),
      .queue_full     (q_full),
      .req_bus        (req_bus),
      .push           (q_push),
      .job            (push_job)
   );

   bec_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .pop      (q_pop),
      .head_job (head_job),
      .full     (q_full),
      .empty    (q_empty)
   );

   bec_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (!q_empty),
      .head_job  (head_job),
      .pop       (q_pop),
      .rsp_bus   (rsp_bus)
   );

   a_no_push_when_full : assert property (@(posedge clock) disable iff (reset)
      q_full |-> !q_push)
      else $error("job pushed into a full queue");

   a_marker_closes_run : assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.field_done) |-> (rsp_bus.last_of_run && !rsp_bus.out_present))
      else $error("end marker not last result or carries a byte");

   a_pop_only_when_loaded : assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty ##1 rsp_bus.valid)
      else $error("queue popped without a result loaded");

   a_reset_empties_queue : assert property (@(posedge clock)
      reset |=> (q_empty && !rsp_bus.valid))
      else $error("queue or result register not cleared by reset");

endmodule

### design/bec_front.sv
module bec_front
   import bec_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       direction,
   input  logic       attribute_mode,
   input  logic       queue_full,
   bec_req_if.sink    req_bus,
   output logic       push,
   output job_type    job
);

   logic       pending_ff;
   logic       pending_in;
   status_type error_ff;
   status_type error_in;
   logic       accept;
   logic [7:0] c;
   logic [7:0] code;
   logic [7:0] dec;
   logic       dec_ok;

   assign req_bus.ready = !queue_full;
   assign accept = req_bus.valid && req_bus.ready;
   assign c = req_bus.data_byte;

   always_comb begin
      code = 8'h00;
      unique case (c)
         CHAR_BSLASH: code = CHAR_BSLASH;
         CHAR_TAB:    code = CHAR_T;
         CHAR_LF:     code = CHAR_N;
         CHAR_CR:     code = CHAR_R;
         CHAR_SPACE:  code = attribute_mode ? CHAR_S : 8'h00;
         default:     code = 8'h00;
      endcase
   end

   always_comb begin
      dec = 8'h00;
      dec_ok = 1'b1;
      unique case (c)
         CHAR_BSLASH: dec = CHAR_BSLASH;
         CHAR_T:      dec = CHAR_TAB;
         CHAR_N:      dec = CHAR_LF;
         CHAR_R:      dec = CHAR_CR;
         CHAR_S: begin
            dec = CHAR_SPACE;
            dec_ok = attribute_mode;
         end
         default:     dec_ok = 1'b0;
      endcase
   end

   always_comb begin
      job = '0;
      job.status = STATUS_OK;
      pending_in = pending_ff;
      error_in = error_ff;
      push = 1'b0;
      if (accept) begin
         if (req_bus.byte_present) begin
            if (direction == DIR_ESCAPE) begin
               if (code != 8'h00) begin
                  job.byte0 = CHAR_BSLASH;
                  job.byte1 = code;
                  job.byte_count = 2'd2;
               end else begin
                  job.byte0 = c;
                  job.byte_count = 2'd1;
               end
            end else if (error_ff == STATUS_OK) begin
               if (pending_ff) begin
                  pending_in = 1'b0;
                  if (dec_ok) begin
                     job.byte0 = dec;
                     job.byte_count = 2'd1;
                  end else begin
                     error_in = STATUS_INVALID;
                  end
               end else if (c == CHAR_BSLASH) begin
                  pending_in = 1'b1;
               end else begin
                  job.byte0 = c;
                  job.byte_count = 2'd1;
               end
            end
         end
         if (req_bus.end_of_field) begin
            job.marker = 1'b1;
            if (error_in != STATUS_OK) begin
               job.status = error_in;
            end else if (pending_in) begin
               job.status = STATUS_DANGLING;
            end else begin
               job.status = STATUS_OK;
            end
            pending_in = 1'b0;
            error_in = STATUS_OK;
         end
         push = (job.byte_count != 2'd0) || job.marker;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 1'b0;
         error_ff <= STATUS_OK;
      end else begin
         pending_ff <= pending_in;
         error_ff <= error_in;
      end
   end

endmodule

### design/bec_queue.sv
module bec_queue
   import bec_pkg::*;
#(
   parameter int unsigned DEPTH = 4
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   input  logic    pop,
   output job_type head_job,
   output logic    full,
   output logic    empty
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   job_type            entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_in;
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;
   logic               do_push;
   logic               do_pop;

   assign full = count_ff == CNT_W'(DEPTH);
   assign empty = count_ff == '0;
   assign do_push = push && !full;
   assign do_pop = pop && !empty;
   assign head_job = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

### design/bec_back.sv
module bec_back
   import bec_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     job_valid,
   input  job_type  head_job,
   output logic     pop,
   bec_rsp_if.source rsp_bus
);

   logic [1:0] idx_ff;
   logic [1:0] idx_in;
   logic [1:0] total;
   logic       is_last;
   logic       load;
   logic       valid_ff;
   logic       valid_in;
   logic [7:0] byte_ff;
   logic [7:0] byte_in;
   logic       present_ff;
   logic       present_in;
   logic       done_ff;
   logic       done_in;
   status_type status_ff;
   status_type status_in;
   logic       last_ff;
   logic       last_in;

   assign total = head_job.byte_count + {1'b0, head_job.marker};
   assign is_last = idx_ff == (total - 2'd1);
   assign load = job_valid && (!valid_ff || rsp_bus.ready);
   assign pop = load && is_last;

   always_comb begin
      idx_in = idx_ff;
      valid_in = valid_ff && !rsp_bus.ready;
      byte_in = byte_ff;
      present_in = present_ff;
      done_in = done_ff;
      status_in = status_ff;
      last_in = last_ff;
      if (load) begin
         valid_in = 1'b1;
         idx_in = is_last ? 2'd0 : idx_ff + 2'd1;
         last_in = is_last;
         if (idx_ff < head_job.byte_count) begin
            byte_in = (idx_ff == 2'd0) ? head_job.byte0 : head_job.byte1;
            present_in = 1'b1;
            done_in = 1'b0;
            status_in = STATUS_OK;
         end else begin
            byte_in = 8'h00;
            present_in = 1'b0;
            done_in = 1'b1;
            status_in = head_job.status;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      present_ff <= present_in;
      done_ff <= done_in;
      status_ff <= status_in;
      last_ff <= last_in;
   end

   assign rsp_bus.valid = valid_ff;
   assign rsp_bus.out_byte = byte_ff;
   assign rsp_bus.out_present = present_ff;
   assign rsp_bus.field_done = done_ff;
   assign rsp_bus.field_status = status_ff;
   assign rsp_bus.last_of_run = last_ff;

endmodule

### sim/tb_backslash_escape_codec_unit.sv
`timescale 1ns / 100ps

module tb_backslash_escape_codec_unit
   import bec_pkg::*;
();

   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned SETTLE_CYCLES = 8;
   localparam int unsigned ITEMS_PER_SEGMENT = 12;
   localparam int unsigned SEGMENTS_PER_PHASE = 3;
   localparam int unsigned NUM_PHASES = 4;
   localparam logic [CSR_ADDR_W-1:0] ADDR_DIRECTION = {REG_DIRECTION, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] ADDR_ATTRIBUTE = {REG_ATTRIBUTE_MODE, 2'b00};

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_present;
      logic       end_of_field;
   } field_item_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_present;
      logic       field_done;
      status_type field_status;
      logic       last_of_run;
   } coded_item_type;

   typedef struct {
      logic       dir;
      logic       attr;
      logic [7:0] data;
      logic       present;
      logic       eof;
      int         typed_n;
      logic [7:0] typed_byte;
      status_type typed_status;
   } stim_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   bec_req_if req_bus ();
   bec_rsp_if rsp_bus ();

   backslash_escape_codec_unit u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   logic           dir_reg = DIR_ESCAPE;
   logic           attr_reg = 1'b0;
   logic           bs_pending = 1'b0;
   status_type     field_err = STATUS_OK;
   coded_item_type coded_q [$];
   int unsigned    fail_count = 0;
   int unsigned    cycle_count = 0;
   int unsigned    send_idle_pct = 0;
   int unsigned    recv_stall_pct = 0;
   stim_row_type   directed_rows [27];

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic coded_item_type byte_out(logic [7:0] b);
      return '{b, 1'b1, 1'b0, STATUS_OK, 1'b0};
   endfunction

   function automatic int code_request(field_item_type r);
      coded_item_type run [3];
      logic [7:0]     code;
      logic [7:0]     dec;
      logic           dec_ok;
      status_type     st;
      int             n;
      n = 0;
      if (r.byte_present) begin
         if (dir_reg == DIR_ESCAPE) begin
            code = 8'h00;
            case (r.data_byte)
               CHAR_BSLASH: code = CHAR_BSLASH;
               CHAR_TAB:    code = CHAR_T;
               CHAR_LF:     code = CHAR_N;
               CHAR_CR:     code = CHAR_R;
               CHAR_SPACE:  if (attr_reg) code = CHAR_S;
               default:     code = 8'h00;
            endcase
            if (code != 8'h00) begin
               run[n] = byte_out(CHAR_BSLASH);
               run[n + 1] = byte_out(code);
               n = n + 2;
            end else begin
               run[n] = byte_out(r.data_byte);
               n = n + 1;
            end
         end else if (field_err == STATUS_OK) begin
            if (bs_pending) begin
               bs_pending = 1'b0;
               dec_ok = 1'b1;
               dec = 8'h00;
               case (r.data_byte)
                  CHAR_BSLASH: dec = CHAR_BSLASH;
                  CHAR_T:      dec = CHAR_TAB;
                  CHAR_N:      dec = CHAR_LF;
                  CHAR_R:      dec = CHAR_CR;
                  CHAR_S: begin
                     dec = CHAR_SPACE;
                     dec_ok = attr_reg;
                  end
                  default:     dec_ok = 1'b0;
               endcase
               if (dec_ok) begin
                  run[n] = byte_out(dec);
                  n = n + 1;
               end else begin
                  field_err = STATUS_INVALID;
               end
            end else if (r.data_byte == CHAR_BSLASH) begin
               bs_pending = 1'b1;
            end else begin
               run[n] = byte_out(r.data_byte);
               n = n + 1;
            end
         end
      end
      if (r.end_of_field) begin
         st = (field_err != STATUS_OK) ? field_err :
              (bs_pending ? STATUS_DANGLING : STATUS_OK);
         run[n] = '{8'h00, 1'b0, 1'b1, st, 1'b0};
         n = n + 1;
         bs_pending = 1'b0;
         field_err = STATUS_OK;
      end
      for (int i = 0; i < n; i++) begin
         run[i].last_of_run = (i == n - 1);
         coded_q = {coded_q, run[i]};
      end
      return n;
   endfunction

   function automatic field_item_type draw_item();
      field_item_type it;
      logic [7:0]  letters [5] = '{CHAR_BSLASH, CHAR_T, CHAR_N, CHAR_R, CHAR_S};
      logic [7:0]  specials [9] = '{CHAR_BSLASH, CHAR_TAB, CHAR_LF, CHAR_CR, CHAR_SPACE,
                                    CHAR_T, CHAR_N, CHAR_R, CHAR_S};
      it.byte_present = ($urandom_range(9) != 0);
      it.end_of_field = ($urandom_range(7) == 0);
      if ($urandom_range(1) == 0)
         it.data_byte = specials[$urandom_range(8)];
      else
         it.data_byte = 8'($urandom_range(255));
      // keep most unescape fields well formed
      if (dir_reg == DIR_UNESCAPE && $urandom_range(3) != 0) begin
         it.byte_present = 1'b1;
         if (bs_pending) begin
            it.data_byte = letters[$urandom_range(attr_reg ? 4 : 3)];
         end else if ($urandom_range(3) == 0) begin
            it.data_byte = CHAR_BSLASH;
            it.end_of_field = 1'b0;
         end else if (it.data_byte == CHAR_BSLASH) begin
            it.data_byte = CHAR_S;
         end
      end
      return it;
   endfunction

   task automatic send_item(input field_item_type it, output int n);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.data_byte <= it.data_byte;
      req_bus.byte_present <= it.byte_present;
      req_bus.end_of_field <= it.end_of_field;
      do begin
         @(posedge clock);
      end while (!req_bus.ready);
      n = code_request(it);
   endtask

   task automatic settle();
      req_bus.valid <= 1'b0;
      while (coded_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_ADDR_W-1:0] addr, input logic value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= {{(CSR_DATA_W - 1){1'b0}}, value};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (addr == ADDR_DIRECTION)
         dir_reg = value;
      else
         attr_reg = value;
      // read back
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (prdata[0] !== value) begin
         fail_count++;
         $display("%0t: register readback at %0d expected %b actual %b",
                  $time, addr, value, prdata[0]);
      end
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   initial begin
      coded_item_type got;
      coded_item_type want;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            got = '{rsp_bus.out_byte, rsp_bus.out_present, rsp_bus.field_done,
                    status_type'(rsp_bus.field_status), rsp_bus.last_of_run};
            if (coded_q.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected result byte=%h present=%b done=%b status=%0d last=%b",
                        $time, got.out_byte, got.out_present, got.field_done,
                        got.field_status, got.last_of_run);
            end else begin
               want = coded_q.pop_front();
               if (got !== want) begin
                  fail_count++;
                  $display("%0t: expected byte=%h present=%b done=%b status=%0d last=%b",
                           $time, want.out_byte, want.out_present, want.field_done,
                           want.field_status, want.last_of_run);
                  $display("%0t: actual   byte=%h present=%b done=%b status=%0d last=%b",
                           $time, got.out_byte, got.out_present, got.field_done,
                           got.field_status, got.last_of_run);
               end
            end
         end
         rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("backslash_escape_codec_unit test failed");
      $finish;
   end

   initial begin
      int unsigned    phase_send [NUM_PHASES];
      int unsigned    phase_recv [NUM_PHASES];
      int unsigned    combo;
      int unsigned    sent;
      int             n;
      stim_row_type   row;
      field_item_type it;
      coded_item_type first_out;
      coded_item_type last_out;

      phase_send = '{0, 59, 0, 38};
      phase_recv = '{0, 0, 59, 38};
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      req_bus.valid = 1'b0;
      req_bus.data_byte = 8'h00;
      req_bus.byte_present = 1'b0;
      req_bus.end_of_field = 1'b0;

      directed_rows = '{
         '{DIR_ESCAPE,   1'b0, 8'h00,       1'b1, 1'b0,  1, 8'h00,       STATUS_OK},
         '{DIR_ESCAPE,   1'b0, 8'hFF,       1'b1, 1'b0,  1, 8'hFF,       STATUS_OK},
         '{DIR_ESCAPE,   1'b0, CHAR_BSLASH, 1'b1, 1'b0,  2, CHAR_BSLASH, STATUS_OK},
         '{DIR_ESCAPE,   1'b0, CHAR_TAB,    1'b1, 1'b0,  2, CHAR_BSLASH, STATUS_OK},
         '{DIR_ESCAPE,   1'b0, CHAR_LF,     1'b1, 1'b0, -1, 8'h00,       STATUS_OK},
         '{DIR_ESCAPE,   1'b0, CHAR_CR,     1'b1, 1'b0, -1, 8'h00,       STATUS_OK},
         '{DIR_ESCAPE,   1'b0, CHAR_SPACE,  1'b1, 1'b1,  2, CHAR_SPACE,  STATUS_OK},
         '{DIR_ESCAPE,   1'b0, 8'h00,       1'b0, 1'b0,  0, 8'h00,       STATUS_OK},
         '{DIR_ESCAPE,   1'b0, 8'hA5,       1'b0, 1'b1,  1, 8'h00,       STATUS_OK},
         '{DIR_ESCAPE,   1'b1, CHAR_SPACE,  1'b1, 1'b1,  3, CHAR_BSLASH, STATUS_OK},
         '{DIR_UNESCAPE, 1'b1, CHAR_BSLASH, 1'b1, 1'b0,  0, 8'h00,       STATUS_OK},
         '{DIR_UNESCAPE, 1'b1, CHAR_S,      1'b1, 1'b0,  1, CHAR_SPACE,  STATUS_OK},
         '{DIR_UNESCAPE, 1'b1, CHAR_BSLASH, 1'b1, 1'b0,  0, 8'h00,       STATUS_OK},
         '{DIR_UNESCAPE, 1'b1, CHAR_BSLASH, 1'b1, 1'b0,  1, CHAR_BSLASH, STATUS_OK},
         '{DIR_UNESCAPE, 1'b1, CHAR_BSLASH, 1'b1, 1'b0,  0, 8'h00,       STATUS_OK},
         '{DIR_UNESCAPE, 1'b1, CHAR_N,      1'b1, 1'b0,  1, CHAR_LF,     STATUS_OK},
         '{DIR_UNESCAPE, 1'b1, CHAR_BSLASH, 1'b1, 1'b1,  1, 8'h00,       STATUS_DANGLING},
         '{DIR_UNESCAPE, 1'b1, CHAR_BSLASH, 1'b1, 1'b0,  0, 8'h00,       STATUS_OK},
         '{DIR_UNESCAPE, 1'b1, 8'h41,       1'b1, 1'b0,  0, 8'h00,       STATUS_OK},
         '{DIR_UNESCAPE, 1'b1, CHAR_T,      1'b1, 1'b1,  1, 8'h00,       STATUS_INVALID},
         '{DIR_UNESCAPE, 1'b0, CHAR_BSLASH, 1'b1, 1'b0,  0, 8'h00,       STATUS_OK},
         '{DIR_UNESCAPE, 1'b0, CHAR_S,      1'b1, 1'b1,  1, 8'h00,       STATUS_INVALID},
         '{DIR_UNESCAPE, 1'b0, CHAR_BSLASH, 1'b1, 1'b0, -1, 8'h00,       STATUS_OK},
         '{DIR_ESCAPE,   1'b0, CHAR_TAB,    1'b1, 1'b0, -1, 8'h00,       STATUS_OK},
         '{DIR_UNESCAPE, 1'b0, CHAR_T,      1'b1, 1'b1, -1, 8'h00,       STATUS_OK},
         '{DIR_UNESCAPE, 1'b0, CHAR_BSLASH, 1'b1, 1'b0, -1, 8'h00,       STATUS_OK},
         '{DIR_ESCAPE,   1'b0, 8'h41,       1'b1, 1'b1,  2, 8'h41,       STATUS_DANGLING}
      };

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.dir !== dir_reg || row.attr !== attr_reg) begin
            settle();
            write_reg(ADDR_DIRECTION, row.dir);
            write_reg(ADDR_ATTRIBUTE, row.attr);
         end
         send_item('{row.data, row.present, row.eof}, n);
         if (row.typed_n >= 0) begin
            if (n != row.typed_n) begin
               fail_count++;
               $display("%0t: request %0d expected %0d results, predicted %0d",
                        $time, i, row.typed_n, n);
            end else if (n > 0) begin
               first_out = coded_q[coded_q.size() - n];
               last_out = coded_q[coded_q.size() - 1];
               if ((first_out.out_present && first_out.out_byte !== row.typed_byte) ||
                   (row.eof && last_out.field_status !== row.typed_status)) begin
                  fail_count++;
                  $display("%0t: row %0d expected byte=%h status=%0d, got byte=%h status=%0d",
                           $time, i, row.typed_byte, row.typed_status,
                           first_out.out_byte, last_out.field_status);
               end
            end
         end
      end

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         for (int seg = 0; seg < SEGMENTS_PER_PHASE; seg++) begin
            settle();
            send_idle_pct = phase_send[phase];
            recv_stall_pct = phase_recv[phase];
            combo = (phase + seg) % 4;
            write_reg(ADDR_DIRECTION, combo[0]);
            write_reg(ADDR_ATTRIBUTE, combo[1]);
            sent = 0;
            while (sent < ITEMS_PER_SEGMENT) begin
               it = draw_item();
               send_item(it, n);
               if (it.byte_present || it.end_of_field)
                  sent++;
            end
         end
      end

      settle();
      if (fail_count == 0)
         $display("backslash_escape_codec_unit test passed");
      else
         $display("backslash_escape_codec_unit test failed");
      $finish;
   end

endmodule
